/* hdl/sfm_pkg.sv */
// Shared types and codes for the substring first-match unit.
package sfm_pkg;

   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int LENGTH_W   = 5;
   localparam int POS_OUT_W  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // item commands
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HAY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NEEDLE_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALFWORD_MODE = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic take_load;
      logic take_hay;
      logic take_end;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic last_issue;
      logic rsp_free;
   } dp_status_type;

endpackage

/* hdl/sfm_ctrl.sv */
// Controller state machine: item acceptance and compare sequencing.
module sfm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [sfm_pkg::CMD_W-1:0]   req_cmd,
   output logic                        req_stall,
   input  sfm_pkg::dp_status_type      status,
   output sfm_pkg::ctrl_cmd_type       ctrl
);

   sfm_pkg::state_type state_ff;
   sfm_pkg::state_type state_in;
   logic               idle;
   logic               hay_taken;

   assign idle      = (state_ff == sfm_pkg::ST_IDLE);
   assign hay_taken = idle && req_valid && (req_cmd == sfm_pkg::CMD_HAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfm_pkg::ST_IDLE: begin
            if (hay_taken && status.scan_needed) state_in = sfm_pkg::ST_SCAN;
         end
         sfm_pkg::ST_SCAN: begin
            if (status.last_issue) state_in = sfm_pkg::ST_CHECK;
         end
         sfm_pkg::ST_CHECK: begin
            state_in = sfm_pkg::ST_IDLE;
         end
         default: begin
            state_in = sfm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sfm_pkg::ST_IDLE: begin
            // an end item waits until the output register can take its result
            req_stall      = (req_cmd == sfm_pkg::CMD_END) && !status.rsp_free;
            ctrl.take_load = req_valid && (req_cmd == sfm_pkg::CMD_LOAD);
            ctrl.take_hay  = hay_taken;
            ctrl.take_end  = req_valid && (req_cmd == sfm_pkg::CMD_END) && status.rsp_free;
         end
         sfm_pkg::ST_SCAN: begin
            ctrl.issue = 1'b1;
         end
         sfm_pkg::ST_CHECK: begin
            ctrl.finish = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* hdl/sfm_datapath.sv */
// Datapath: needle store, window buffer, element compare, match state and result register.
module sfm_datapath #(
   parameter int MAX_NEEDLE    = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sfm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfm_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [sfm_pkg::VALUE_W-1:0]      req_value,
   input  logic [sfm_pkg::SLOT_W-1:0]       req_slot,
   input  sfm_pkg::ctrl_cmd_type            ctrl,
   output sfm_pkg::dp_status_type           status,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [sfm_pkg::POS_OUT_W-1:0]    rsp_position
);

   localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
   localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
   localparam int CW    = POSITION_BITS + LEN_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NEEDLE - 1);

   logic [sfm_pkg::VALUE_W-1:0]  needle_mem [MAX_NEEDLE];
   logic [sfm_pkg::VALUE_W-1:0]  window_mem [MAX_NEEDLE];
   logic [sfm_pkg::VALUE_W-1:0]  needle_rd_ff;
   logic [sfm_pkg::VALUE_W-1:0]  window_rd_ff;

   logic [sfm_pkg::LENGTH_W-1:0] needle_length_ff, needle_length_in;
   logic                         halfword_ff, halfword_in;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic [POSITION_BITS-1:0]     count_ff, count_in;
   logic                         match_seen_ff, match_seen_in;
   logic [POSITION_BITS-1:0]     match_start_ff, match_start_in;
   logic [IDX_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         mismatch_ff, mismatch_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [sfm_pkg::POS_OUT_W-1:0] rsp_position_ff, rsp_position_in;

   logic [LEN_W-1:0]             used_len;
   logic [IDX_W-1:0]             len_m1;
   logic [IDX_W-1:0]             head_next;
   logic [IDX_W-1:0]             start_ptr;
   logic [IDX_W-1:0]             slot_idx;
   logic                         slot_ok;
   logic                         count_full;
   logic [POSITION_BITS-1:0]     count_next;
   logic                         elem_diff;
   logic                         hit;

   assign used_len = (int'(needle_length_ff) > MAX_NEEDLE) ? LEN_W'(MAX_NEEDLE)
                                                            : LEN_W'(needle_length_ff);
   assign len_m1     = IDX_W'(used_len - 1'b1);
   assign head_next  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign count_full = &count_ff;
   assign count_next = count_ff + 1'b1;
   assign slot_idx   = IDX_W'(req_slot);
   assign slot_ok    = (int'(req_slot) < MAX_NEEDLE);

   // oldest element of the compare window, in circular buffer order
   always_comb begin
      if (head_next >= len_m1) begin
         start_ptr = head_next - len_m1;
      end else begin
         start_ptr = IDX_W'({1'b0, head_next} + (IDX_W + 1)'(MAX_NEEDLE) - {1'b0, len_m1});
      end
   end

   assign elem_diff = halfword_ff ? (needle_rd_ff != window_rd_ff)
                                  : (needle_rd_ff[7:0] != window_rd_ff[7:0]);
   assign hit       = !mismatch_ff && !(rd_valid_ff && elem_diff);

   assign status.scan_needed = !count_full && !match_seen_ff && (used_len != '0)
                               && (CW'(count_next) >= CW'(used_len));
   assign status.last_issue  = (idx_ff == len_m1);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   // needle store: written by load items, read one entry per compare step
   always_ff @(posedge clock) begin
      if (ctrl.take_load && slot_ok) needle_mem[slot_idx] <= req_value;
      if (ctrl.issue) needle_rd_ff <= needle_mem[idx_ff];
   end

   // window of the newest haystack elements as a circular buffer
   always_ff @(posedge clock) begin
      if (ctrl.take_hay && !count_full) window_mem[head_next] <= req_value;
      if (ctrl.issue) window_rd_ff <= window_mem[rd_ptr_ff];
   end

   always_comb begin
      needle_length_in = needle_length_ff;
      halfword_in      = halfword_ff;
      head_in          = head_ff;
      count_in         = count_ff;
      match_seen_in    = match_seen_ff;
      match_start_in   = match_start_ff;
      rd_ptr_in        = rd_ptr_ff;
      idx_in           = idx_ff;
      mismatch_in      = mismatch_ff;
      rd_valid_in      = ctrl.issue;
      rsp_valid_in     = rsp_valid_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_position_in  = rsp_position_ff;

      if (csr_we) begin
         unique case (csr_index)
            sfm_pkg::REG_NEEDLE_LENGTH: needle_length_in = csr_data[sfm_pkg::LENGTH_W-1:0];
            sfm_pkg::REG_HALFWORD_MODE: halfword_in      = csr_data[0];
            default: ;
         endcase
      end

      if (rd_valid_ff && elem_diff) mismatch_in = 1'b1;

      // saturated count: element dropped
      if (ctrl.take_hay && !count_full) begin
         head_in     = head_next;
         count_in    = count_next;
         rd_ptr_in   = start_ptr;
         idx_in      = '0;
         mismatch_in = 1'b0;
      end

      if (ctrl.issue) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
         idx_in    = idx_ff + 1'b1;
      end

      if (ctrl.finish && hit) begin
         match_seen_in  = 1'b1;
         match_start_in = POSITION_BITS'(CW'(count_ff) - CW'(used_len));
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (ctrl.take_end) begin
         rsp_valid_in = 1'b1;
         if (used_len == '0) begin
            rsp_found_in    = 1'b1;
            rsp_position_in = '0;
         end else if (match_seen_ff) begin
            rsp_found_in    = 1'b1;
            rsp_position_in = sfm_pkg::POS_OUT_W'(match_start_ff);
         end else begin
            rsp_found_in    = 1'b0;
            rsp_position_in = sfm_pkg::POS_OUT_W'(count_ff);
         end
         count_in       = '0;
         match_seen_in  = 1'b0;
         match_start_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= '0;
         halfword_ff      <= 1'b0;
         head_ff          <= '0;
         count_ff         <= '0;
         match_seen_ff    <= 1'b0;
         match_start_ff   <= '0;
         mismatch_ff      <= 1'b0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         needle_length_ff <= needle_length_in;
         halfword_ff      <= halfword_in;
         head_ff          <= head_in;
         count_ff         <= count_in;
         match_seen_ff    <= match_seen_in;
         match_start_ff   <= match_start_in;
         mismatch_ff      <= mismatch_in;
         rd_valid_ff      <= rd_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff       <= rd_ptr_in;
      idx_ff          <= idx_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

/* hdl/substring_first_match_unit.sv */
// Top level of the substring first-match unit: controller plus datapath.
//
// Finds the first occurrence of a loaded needle in a streamed haystack. Load,
// end and unused-command items are taken in the idle state and start no compare.
// A haystack item starts none when no compare is due (match already found, empty
// needle, fewer elements than the needle, or saturated count); otherwise new items
// are stalled while the last L elements are compared, L being needle_length clamped
// to MAX_NEEDLE: the window is compared with the needle one element per cycle
// through the single read ports of the needle store and the window buffer, and a
// check state then settles the verdict. An end item is held while an unread result
// sits in the output register. No clearing pass follows reset.
module substring_first_match_unit #(
   parameter int MAX_NEEDLE    = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfm_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sfm_pkg::CMD_W-1:0]         req_cmd,
   input  logic [sfm_pkg::VALUE_W-1:0]       req_value,
   input  logic [sfm_pkg::SLOT_W-1:0]        req_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [sfm_pkg::POS_OUT_W-1:0]     rsp_position
);

   sfm_pkg::ctrl_cmd_type  ctrl;
   sfm_pkg::dp_status_type status;

   sfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   sfm_datapath #(
      .MAX_NEEDLE    (MAX_NEEDLE),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_value    (req_value),
      .req_slot     (req_slot),
      .ctrl         (ctrl),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

endmodule

/* hdl/sfm_checker.sv */
// Port-level checks for the substring first-match unit, bound to the top level.
module sfm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [sfm_pkg::CMD_W-1:0]      req_cmd,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_found,
   input logic [sfm_pkg::POS_OUT_W-1:0]  rsp_position
);

   logic end_taken;
   logic load_taken;

   assign end_taken  = req_valid && !req_stall && (req_cmd == sfm_pkg::CMD_END);
   assign load_taken = req_valid && !req_stall && (req_cmd == sfm_pkg::CMD_LOAD);

   // a waiting result holds still
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // every accepted end item shows a result on the next cycle
   property p_end_reports;
      @(posedge clock) disable iff (reset)
         end_taken |=> rsp_valid;
   endproperty
   a_end_reports: assert property (p_end_reports) else $error("end item gave no result");

   // a result only appears after an end item
   property p_no_spurious;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid) |-> $past(end_taken);
   endproperty
   a_no_spurious: assert property (p_no_spurious) else $error("result without end item");

   // a load item never leaves the unit busy
   property p_load_single;
      @(posedge clock) disable iff (reset)
         load_taken |=> !req_stall || (req_cmd == sfm_pkg::CMD_END);
   endproperty
   a_load_single: assert property (p_load_single) else $error("busy after load item");

endmodule

bind substring_first_match_unit sfm_checker u_sfm_checker (.*);

/* bench/substring_first_match_unit_tb.sv */
// Self-checking testbench for the substring first-match unit: directed table, then random traffic.
module substring_first_match_unit_tb;

   localparam int MAX_NEEDLE     = 16;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int PHASES         = 30;
   localparam int SETTLE_CYCLES  = MAX_NEEDLE + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [sfm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [sfm_pkg::CSR_IDX_W-1:0] LEN_REG  = sfm_pkg::REG_NEEDLE_LENGTH;
   localparam logic [sfm_pkg::CSR_IDX_W-1:0] HALF_REG = sfm_pkg::REG_HALFWORD_MODE;

   typedef struct packed {
      logic                          found;
      logic [sfm_pkg::POS_OUT_W-1:0] position;
   } search_report_type;

   typedef struct packed {
      logic                           reg_write;
      logic [sfm_pkg::CSR_IDX_W-1:0]  reg_index;
      logic [sfm_pkg::CSR_DATA_W-1:0] reg_value;
      logic [sfm_pkg::CMD_W-1:0]      cmd;
      logic [sfm_pkg::VALUE_W-1:0]    value;
      logic [sfm_pkg::SLOT_W-1:0]     slot;
      logic                           pinned;
      logic                           found;
      logic [sfm_pkg::POS_OUT_W-1:0]  position;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty needle straight after reset
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_END,  16'h0000, 4'd0,  1'b1, 1'b1, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'hFFFF, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  CMD_UNUSED,        16'hFFFF, 4'd15, 1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_END,  16'h0000, 4'd0,  1'b1, 1'b1, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_LOAD, 16'h0000, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_LOAD, 16'hFFFF, 4'd1,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_LOAD, 16'hFFFF, 4'd15, 1'b0, 1'b0, 32'd0},
      '{1'b1, LEN_REG,  5'd2,  sfm_pkg::CMD_LOAD, 16'h0000, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b1, HALF_REG, 5'd1,  sfm_pkg::CMD_LOAD, 16'h0000, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'h0000, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'hFFFF, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_END,  16'hFFFF, 4'd15, 1'b0, 1'b0, 32'd0},
      // haystack shorter than the needle
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'h0001, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_END,  16'h0000, 4'd0,  1'b1, 1'b0, 32'd1},
      '{1'b1, HALF_REG, 5'd0,  sfm_pkg::CMD_LOAD, 16'h0000, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'h1200, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'h34FF, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_END,  16'h0000, 4'd0,  1'b0, 1'b0, 32'd0},
      // length changed mid-haystack, over-long length clamps to the store depth
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'h5500, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b1, LEN_REG,  5'd31, sfm_pkg::CMD_LOAD, 16'h0000, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'hAAAA, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_HAY,  16'h0F0F, 4'd0,  1'b0, 1'b0, 32'd0},
      '{1'b0, LEN_REG,  5'd0,  sfm_pkg::CMD_END,  16'h0000, 4'd0,  1'b1, 1'b0, 32'd3}
   };

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [sfm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sfm_pkg::CSR_DATA_W-1:0] csr_data;
   logic                           req_valid;
   logic                           req_stall;
   logic [sfm_pkg::CMD_W-1:0]      req_cmd;
   logic [sfm_pkg::VALUE_W-1:0]    req_value;
   logic [sfm_pkg::SLOT_W-1:0]     req_slot;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_found;
   logic [sfm_pkg::POS_OUT_W-1:0]  rsp_position;

   // typed expectation travelling with the current item
   logic                           req_pinned;
   search_report_type              req_pinned_report;

   // predictor state
   logic [sfm_pkg::VALUE_W-1:0]    needle_mem [MAX_NEEDLE] = '{default: '0};
   logic [sfm_pkg::VALUE_W-1:0]    hay_window [MAX_NEEDLE] = '{default: '0};
   logic [31:0]                    hay_count = '0;
   logic [31:0]                    first_start = '0;
   logic                           match_seen = 1'b0;
   logic [sfm_pkg::LENGTH_W-1:0]   cfg_length = '0;
   logic                           cfg_halfword = 1'b0;

   search_report_type              expected_reports [$];
   logic [sfm_pkg::VALUE_W-1:0]    needle_shadow [MAX_NEEDLE] = '{default: '0};

   int                             send_idle_pct = 9;
   int                             rsp_idle_pct = 46;
   int                             mismatch_count = 0;
   int                             reports_checked = 0;
   int                             items_sent = 0;
   int                             reg_writes = 0;
   int                             quiet_cycles = 0;

   substring_first_match_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .req_slot     (req_slot),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   task automatic predict_search(input logic [sfm_pkg::CMD_W-1:0] cmd,
                                 input logic [sfm_pkg::VALUE_W-1:0] value,
                                 input logic [sfm_pkg::SLOT_W-1:0] slot, input logic pin,
                                 input search_report_type pin_rep);
      int unsigned       used;
      logic [15:0]       mask;
      logic              hit;
      search_report_type rep;
      used = (cfg_length > MAX_NEEDLE) ? MAX_NEEDLE : cfg_length;
      mask = cfg_halfword ? 16'hFFFF : 16'h00FF;
      case (cmd)
         sfm_pkg::CMD_LOAD: begin
            needle_mem[slot] = value;
         end
         sfm_pkg::CMD_HAY: begin
            // a saturated count drops the element entirely
            if (hay_count != '1) begin
               for (int k = MAX_NEEDLE - 1; k > 0; k--) hay_window[k] = hay_window[k-1];
               hay_window[0] = value;
               hay_count = hay_count + 1;
               if (!match_seen && used != 0 && hay_count >= used) begin
                  hit = 1'b1;
                  for (int j = 0; j < used; j++)
                     if ((hay_window[used-1-j] & mask) != (needle_mem[j] & mask)) hit = 1'b0;
                  if (hit) begin
                     match_seen = 1'b1;
                     first_start = hay_count - used;
                  end
               end
            end
         end
         sfm_pkg::CMD_END: begin
            if (used == 0) rep = '{found: 1'b1, position: '0};
            else if (match_seen) rep = '{found: 1'b1, position: first_start};
            else rep = '{found: 1'b0, position: hay_count};
            expected_reports.push_back(pin ? pin_rep : rep);
            hay_window = '{default: '0};
            hay_count = '0;
            first_start = '0;
            match_seen = 1'b0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      search_report_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: report with nothing pending: expected none, actual found=%0d pos=%0d",
                        $time, rsp_found, rsp_position);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               reports_checked++;
               if (rsp_found !== want.found) begin
                  $display("%0t: found: expected %0d, actual %0d", $time, want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_position !== want.position) begin
                  $display("%0t: position: expected %0d, actual %0d",
                           $time, want.position, rsp_position);
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               sfm_pkg::REG_NEEDLE_LENGTH: cfg_length = csr_data[sfm_pkg::LENGTH_W-1:0];
               sfm_pkg::REG_HALFWORD_MODE: cfg_halfword = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_search(req_cmd, req_value, req_slot, req_pinned, req_pinned_report);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d reports outstanding",
                     $time, expected_reports.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic logic [sfm_pkg::VALUE_W-1:0] alphabet_value();
      logic [7:0] hi;
      // few symbols so that partial matches are common
      hi = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00;
      return {hi, 8'($urandom_range(2))};
   endfunction

   task automatic push_item(input logic [sfm_pkg::CMD_W-1:0] cmd,
                            input logic [sfm_pkg::VALUE_W-1:0] value,
                            input logic [sfm_pkg::SLOT_W-1:0] slot, input logic pin,
                            input search_report_type pin_rep);
      csr_we <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_value <= value;
      req_slot <= slot;
      req_pinned <= pin;
      req_pinned_report <= pin_rep;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == sfm_pkg::CMD_LOAD) needle_shadow[slot] = value;
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   task automatic write_reg(input logic [sfm_pkg::CSR_IDX_W-1:0] index,
                            input logic [sfm_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      reg_writes++;
      @(posedge clock);
   endtask

   // block idle: any compare in flight has drained and no report is pending
   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_we <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   initial begin
      int                           phase;
      int                           phase_end;
      int                           pick;
      int unsigned                  used;
      int unsigned                  bad;
      logic [sfm_pkg::LENGTH_W-1:0] len;
      logic                         half;
      logic [sfm_pkg::VALUE_W-1:0]  v;
      stim_row_type                 row;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_cmd = sfm_pkg::CMD_LOAD;
      req_value = '0;
      req_slot = '0;
      req_pinned = 1'b0;
      req_pinned_report = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.reg_write) begin
            wait_idle();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            push_item(row.cmd, row.value, row.slot, row.pinned,
                      search_report_type'{row.found, row.position});
         end
      end

      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         wait_idle();
         case ((phase * 3) / PHASES)
            0: begin send_idle_pct = 9;  rsp_idle_pct = 46; end
            1: begin send_idle_pct = 46; rsp_idle_pct = 9;  end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         case (phase)
            0: begin len = 5'd16; half = 1'b0; end
            1: begin len = 5'd1;  half = 1'b1; end
            2: begin len = 5'd0;  half = 1'b0; end
            3: begin len = 5'd31; half = 1'b1; end
            default: begin
               len = ($urandom_range(9) < 7) ? 5'($urandom_range(1, 6)) : 5'($urandom_range(31));
               half = 1'($urandom);
            end
         endcase
         write_reg(sfm_pkg::REG_NEEDLE_LENGTH, len);
         write_reg(sfm_pkg::REG_HALFWORD_MODE, sfm_pkg::CSR_DATA_W'(half));
         // fill the whole store before anything is compared against it
         if (phase == 0)
            for (int s = 0; s < MAX_NEEDLE; s++)
               push_item(sfm_pkg::CMD_LOAD, alphabet_value(), sfm_pkg::SLOT_W'(s), 1'b0, '0);
         used = (len > MAX_NEEDLE) ? MAX_NEEDLE : len;
         phase_end = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               repeat ($urandom_range(6))
                  push_item(sfm_pkg::CMD_HAY, alphabet_value(), 4'($urandom), 1'b0, '0);
               if ($urandom_range(4) != 0) begin
                  bad = ($urandom_range(3) == 0) ? $urandom_range(used) : MAX_NEEDLE;
                  for (int j = 0; j < used; j++) begin
                     v = needle_shadow[j];
                     if (!half) v[15:8] = 8'($urandom_range(255));
                     if (j == bad) v = v ^ 16'h0001;
                     push_item(sfm_pkg::CMD_HAY, v, 4'($urandom), 1'b0, '0);
                  end
               end
               repeat ($urandom_range(3))
                  push_item(sfm_pkg::CMD_HAY, alphabet_value(), 4'($urandom), 1'b0, '0);
               push_item(sfm_pkg::CMD_END, 16'($urandom), 4'($urandom), 1'b0, '0);
            end else if (pick < 75) begin
               repeat ($urandom_range(1, 4))
                  push_item(sfm_pkg::CMD_LOAD,
                            ($urandom_range(4) == 0) ? 16'($urandom) : alphabet_value(),
                            4'($urandom), 1'b0, '0);
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 5))
                  push_item(2'($urandom), 16'($urandom), 4'($urandom), 1'b0, '0);
            end else begin
               repeat ($urandom_range(4))
                  push_item(sfm_pkg::CMD_HAY, alphabet_value(), 4'($urandom), 1'b0, '0);
               push_item(sfm_pkg::CMD_END, 16'($urandom), 4'($urandom), 1'b0, '0);
            end
         end
         phase++;
      end

      wait_idle();
      $display("Run covered %0d random items over %0d register settings (%0d register writes),",
               items_sent, phase, reg_writes);
      $display("with %0d search reports checked field by field", reports_checked);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/sfm_pkg.sv
hdl/sfm_ctrl.sv
hdl/sfm_datapath.sv
hdl/substring_first_match_unit.sv
hdl/sfm_checker.sv
bench/substring_first_match_unit_tb.sv
